// File: hdl/ktt_pkg.sv
// Package for the keyframe track table.
// Holds the opcode width, opcodes and sequencer state type; no dependencies.
package ktt_pkg;
   localparam int OpcodeBits = 3;
   localparam logic [OpcodeBits-1:0] OP_EVAL   = 3'd0;
   localparam logic [OpcodeBits-1:0] OP_CHANGE = 3'd1;
   localparam logic [OpcodeBits-1:0] OP_INS    = 3'd2;
   localparam logic [OpcodeBits-1:0] OP_REM    = 3'd3;
   localparam logic [OpcodeBits-1:0] OP_QUERY  = 3'd4;
   localparam logic [OpcodeBits-1:0] OP_SETCLR = 3'd5;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_READ  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_WRITE = 6'b001000,
      ST_MOVE  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;
endpackage

// File: hdl/ktt_ram.sv
// Generic single write port, single read port RAM with registered read.
// Used for the step and value stores of the keyframe track table.
module ktt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// File: hdl/keyframe_track_table_top.sv
// Keyframe track table: sorted (step, value) key store with six edit/lookup operations.
// Each request scans the keys in order from the first; an insert or delete shifts the
// entries behind the edit point one at a time, and a time shift that drops keys shifts
// once per drop. One transaction at a time: a new request is taken only while idle with
// no result pending. Synchronous active-high reset clears key count and held value; key
// RAM is not cleared. Depends on ktt_pkg and ktt_ram.
module keyframe_track_table_top #(
   parameter int TABLE_DEPTH = 64,
   parameter int VALUE_BITS  = 32,
   parameter int STEP_BITS   = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], step[34:3], shift[66:35], value[98:67], flag[99], zero fill
   input  logic [103:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // changed[0], current_value[32:1], key_count[39:33], status[40], zero fill
   output logic [47:0]  rsp_tdata
);
   import ktt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [STEP_BITS-1:0] StepMax = {STEP_BITS{1'b1}};
   localparam logic [STEP_BITS-1:0] StepOne = STEP_BITS'(1);
   localparam logic [CW-1:0] Depth = CW'(TABLE_DEPTH);

   // per-transaction registers
   state_type             state_ff, state_in;
   logic [OpcodeBits-1:0] op_ff, op_in;
   logic [STEP_BITS-1:0]  s_ff, s_in, amt_ff, amt_in;
   logic [VALUE_BITS-1:0] v_ff, v_in, held_ff, held_in;
   logic                  flag_ff, flag_in, chg_ff, chg_in, full_ff, full_in;
   logic                  pin_ff, pin_in, sel_ok_ff, sel_ok_in;
   logic [CW-1:0]         cnt_ff, cnt_in, idx_ff, idx_in, sel_ff, sel_in;
   // move engine: copy entries from src to dst, up or down
   logic [CW-1:0]         mv_src_ff, mv_src_in, mv_end_ff, mv_end_in;
   logic                  mv_up_ff, mv_up_in, mv_ph_ff, mv_ph_in;
   logic [STEP_BITS-1:0]  ins_s_ff, ins_s_in;
   logic [VALUE_BITS-1:0] ins_v_ff, ins_v_in;
   logic                  rsp_v_ff, rsp_v_in;
   logic [47:0]           rsp_d_ff, rsp_d_in;

   // RAM ports
   logic                  we;
   logic [AW-1:0]         waddr, raddr;
   logic [STEP_BITS-1:0]  wstep, rstep;
   logic [VALUE_BITS-1:0] wval, rval;
   logic                  wst_en, wvl_en;

   ktt_ram #(.WIDTH(STEP_BITS), .DEPTH(TABLE_DEPTH)) u_steps (
      .clock(clock), .wr_en(wst_en), .wr_addr(waddr), .wr_data(wstep),
      .rd_addr(raddr), .rd_data(rstep));
   ktt_ram #(.WIDTH(VALUE_BITS), .DEPTH(TABLE_DEPTH)) u_vals (
      .clock(clock), .wr_en(wvl_en), .wr_addr(waddr), .wr_data(wval),
      .rd_addr(raddr), .rd_data(rval));

   assign req_tready = state_ff == ST_IDLE && !rsp_v_ff;
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   // shared compare/adder results on the entry just read
   logic s_lt, s_eq;
   logic [STEP_BITS-1:0] rem_end, limit;
   assign s_lt = rstep < s_ff;
   assign s_eq = rstep == s_ff;
   assign limit = StepMax - amt_ff;
   assign rem_end = (amt_ff > StepMax - s_ff) ? StepMax : s_ff + amt_ff;

   always_comb begin
      state_in = state_ff; op_in = op_ff; s_in = s_ff; amt_in = amt_ff; v_in = v_ff;
      flag_in = flag_ff; held_in = held_ff; chg_in = chg_ff; full_in = full_ff;
      pin_in = pin_ff; sel_ok_in = sel_ok_ff; sel_in = sel_ff;
      cnt_in = cnt_ff; idx_in = idx_ff;
      mv_src_in = mv_src_ff; mv_end_in = mv_end_ff; mv_up_in = mv_up_ff;
      mv_ph_in = mv_ph_ff; ins_s_in = ins_s_ff; ins_v_in = ins_v_ff;
      rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      raddr = idx_ff[AW-1:0]; waddr = idx_ff[AW-1:0];
      wstep = rstep; wval = rval; wst_en = 1'b0; wvl_en = 1'b0; we = 1'b0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in = req_tdata[2:0];
               s_in = req_tdata[3 +: STEP_BITS];
               amt_in = req_tdata[35 +: STEP_BITS];
               v_in = req_tdata[67 +: VALUE_BITS];
               flag_in = req_tdata[99];
               chg_in = 1'b0; full_in = 1'b0; pin_in = 1'b0; sel_ok_in = 1'b0;
               sel_in = '0; idx_in = '0;
               state_in = ST_READ;
            end
         end
         // issue read of entry idx, or finish the scan past the end
         ST_READ: begin
            if (idx_ff >= cnt_ff) state_in = ST_WRITE;
            else state_in = ST_SCAN;
         end
         // examine entry idx
         ST_SCAN: begin
            state_in = ST_READ;
            case (op_ff)
               OP_EVAL: begin
                  if (rstep > s_ff) state_in = ST_WRITE;
                  else begin
                     sel_in = idx_ff; idx_in = idx_ff + 1'b1;
                  end
               end
               OP_CHANGE: begin
                  if (s_lt) idx_in = idx_ff + 1'b1;
                  else if (s_eq || !flag_ff) begin
                     sel_in = (s_eq || idx_ff == '0) ? idx_ff : idx_ff - 1'b1;
                     sel_ok_in = 1'b1; state_in = ST_WRITE;
                  end else state_in = ST_WRITE;
               end
               OP_QUERY, OP_SETCLR: begin
                  if (s_eq) begin
                     sel_ok_in = 1'b1; state_in = ST_WRITE;
                  end else if (rstep > s_ff) state_in = ST_WRITE;
                  else idx_in = idx_ff + 1'b1;
               end
               OP_INS: begin
                  idx_in = idx_ff + 1'b1;
                  if (!(s_lt || rstep == StepOne)) begin
                     if (pin_ff) begin
                        chg_in = 1'b1; state_in = ST_MOVE;
                        mv_up_in = 1'b0; mv_ph_in = 1'b0;
                        mv_src_in = idx_ff + 1'b1; idx_in = idx_ff;
                     end else begin
                        we = 1'b1; wst_en = 1'b1;
                        if (rstep >= limit) begin
                           wstep = StepMax; pin_in = 1'b1;
                        end else wstep = rstep + amt_ff;
                        if (wstep != rstep) chg_in = 1'b1;
                     end
                  end
               end
               OP_REM: begin
                  idx_in = idx_ff + 1'b1;
                  if (!(s_lt || rstep == StepOne)) begin
                     if (rstep < rem_end) begin
                        chg_in = 1'b1; state_in = ST_MOVE;
                        mv_up_in = 1'b0; mv_ph_in = 1'b0;
                        mv_src_in = idx_ff + 1'b1; idx_in = idx_ff;
                     end else begin
                        we = 1'b1; wst_en = 1'b1; wstep = rstep - amt_ff;
                        if (amt_ff != '0) chg_in = 1'b1;
                     end
                  end
               end
               default: state_in = ST_DONE;
            endcase
         end
         // decide the edit; sel/idx were read where needed
         ST_WRITE: begin
            state_in = ST_DONE;
            raddr = sel_ff[AW-1:0];
            case (op_ff)
               OP_EVAL: begin
                  if (cnt_ff != '0) begin
                     if (!mv_ph_ff) begin
                        mv_ph_in = 1'b1; state_in = ST_WRITE;
                     end else begin
                        mv_ph_in = 1'b0;
                        if (rval != held_ff) chg_in = 1'b1;
                        held_in = rval;
                     end
                  end
               end
               OP_CHANGE: begin
                  if (!flag_ff && cnt_ff == '0) begin
                     if (held_ff != v_ff) chg_in = 1'b1;
                     held_in = v_ff;
                  end else if (sel_ok_ff || !flag_ff) begin
                     if (!sel_ok_ff) sel_in = cnt_ff - 1'b1;
                     raddr = sel_in[AW-1:0];
                     if (!mv_ph_ff) begin
                        mv_ph_in = 1'b1; state_in = ST_WRITE;
                     end else begin
                        mv_ph_in = 1'b0;
                        if (!sel_ok_ff || rval != v_ff) begin
                           chg_in = 1'b1; wvl_en = 1'b1; wval = v_ff;
                           waddr = sel_ff[AW-1:0]; we = 1'b1;
                        end
                     end
                  end else if (cnt_ff >= Depth) full_in = 1'b1;
                  else begin
                     chg_in = 1'b1; state_in = ST_MOVE; mv_up_in = 1'b1;
                     ins_s_in = s_ff; ins_v_in = v_ff; mv_src_in = cnt_ff;
                     mv_end_in = idx_ff; mv_ph_in = 1'b0;
                  end
               end
               OP_QUERY: chg_in = sel_ok_ff;
               OP_SETCLR: begin
                  if (flag_ff && !sel_ok_ff) begin
                     if (cnt_ff >= Depth) full_in = 1'b1;
                     else begin
                        chg_in = 1'b1; state_in = ST_MOVE; mv_up_in = 1'b1;
                        ins_s_in = s_ff; ins_v_in = held_ff;
                        mv_src_in = cnt_ff; mv_end_in = idx_ff; mv_ph_in = 1'b0;
                     end
                  end else if (!flag_ff && sel_ok_ff) begin
                     raddr = idx_ff[AW-1:0];
                     if (!mv_ph_ff) begin
                        mv_ph_in = 1'b1; state_in = ST_WRITE;
                     end else begin
                        if (cnt_ff == CW'(1)) held_in = rval;
                        chg_in = 1'b1; state_in = ST_MOVE; mv_up_in = 1'b0;
                        mv_ph_in = 1'b0; mv_src_in = idx_ff + 1'b1;
                     end
                  end
               end
               default: ;
            endcase
         end
         // entry move engine: one read then one write per entry
         ST_MOVE: begin
            if (mv_up_ff) begin
               // copy src-1 to src down to end, then place the new key at end
               raddr = AW'(mv_src_ff - 1'b1);
               if (mv_src_ff == mv_end_ff) begin
                  we = 1'b1; wst_en = 1'b1; wvl_en = 1'b1;
                  waddr = mv_end_ff[AW-1:0]; wstep = ins_s_ff; wval = ins_v_ff;
                  cnt_in = cnt_ff + 1'b1; state_in = ST_DONE;
               end else if (!mv_ph_ff) mv_ph_in = 1'b1;
               else begin
                  mv_ph_in = 1'b0; we = 1'b1; wst_en = 1'b1; wvl_en = 1'b1;
                  waddr = mv_src_ff[AW-1:0]; mv_src_in = mv_src_ff - 1'b1;
               end
            end else begin
               // copy src to src-1 until the end of table, then shrink
               raddr = mv_src_ff[AW-1:0];
               if (mv_src_ff >= cnt_ff) begin
                  cnt_in = cnt_ff - 1'b1;
                  if (op_ff == OP_SETCLR) state_in = ST_DONE;
                  else state_in = ST_READ;
               end else if (!mv_ph_ff) mv_ph_in = 1'b1;
               else begin
                  mv_ph_in = 1'b0; we = 1'b1; wst_en = 1'b1; wvl_en = 1'b1;
                  waddr = AW'(mv_src_ff - 1'b1); mv_src_in = mv_src_ff + 1'b1;
               end
            end
         end
         ST_DONE: begin
            rsp_v_in = 1'b1;
            rsp_d_in = {7'b0, full_ff, 7'(cnt_ff), 32'(held_ff), chg_ff};
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; cnt_ff <= '0; held_ff <= '0; rsp_v_ff <= 1'b0;
         mv_ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; held_ff <= held_in; rsp_v_ff <= rsp_v_in;
         mv_ph_ff <= mv_ph_in;
      end
      op_ff <= op_in; s_ff <= s_in; amt_ff <= amt_in; v_ff <= v_in; flag_ff <= flag_in;
      chg_ff <= chg_in; full_ff <= full_in; pin_ff <= pin_in; sel_ok_ff <= sel_ok_in;
      sel_ff <= sel_in; idx_ff <= idx_in; mv_src_ff <= mv_src_in; mv_end_ff <= mv_end_in;
      mv_up_ff <= mv_up_in; ins_s_ff <= ins_s_in; ins_v_ff <= ins_v_in;
      rsp_d_ff <= rsp_d_in;
   end

   // key count never exceeds the depth
   a_cnt: assert property (@(posedge clock) disable iff (reset) cnt_ff <= Depth)
      else $error("key count overflow");
   // a full flag implies no change reported
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff && rsp_d_ff[40] |-> !rsp_d_ff[0]) else $error("full with change");
   // no new request taken while a result is pending
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_v_ff |-> !req_tready) else $error("ready while result pending");
   // only the scan, write and move states write the table
   a_we: assert property (@(posedge clock) disable iff (reset)
      we |-> (state_ff == ST_SCAN || state_ff == ST_WRITE || state_ff == ST_MOVE))
      else $error("stray table write");
endmodule
